[rtl/ihist_pkg.sv]
// Shared types, sizes and helpers for the interval histogram.
// No dependencies; every other file but ihist_ram imports this package.
package ihist_pkg;

	localparam int MAX_BINS   = 1024;
	localparam int COUNT_BITS = 32;

	localparam int VAL_W   = 32;
	localparam int WID_W   = 20;
	localparam int CNTR_W  = 11;
	localparam int SEL_W   = 10;
	localparam int FREQ_W  = 32;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam int IDX_W   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int USED_W  = $clog2(MAX_BINS + 1);
	localparam int CMP_W   = (USED_W > CNTR_W) ? USED_W : CNTR_W;
	localparam int PROD_W  = USED_W + WID_W;
	localparam int DIV_W   = (PROD_W > VAL_W) ? PROD_W : VAL_W;
	localparam int STEP_W  = $clog2(IDX_W + 1);

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_WIDTH = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	localparam logic [VAL_W-1:0]  START_RST = '0;
	localparam logic [WID_W-1:0]  WIDTH_RST = WID_W'(10);
	localparam logic [CNTR_W-1:0] COUNT_RST = CNTR_W'(10);

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		logic [VAL_W-1:0]  start;
		logic [WID_W-1:0]  width;
		logic [CNTR_W-1:0] count;
	} cfg_t;

	typedef struct packed {
		logic             ram;
		logic             inc;
		logic             clr;
		idx_t             addr;
		logic [SEL_W-1:0] index;
		logic             in_range;
		logic             last;
	} op_t;

	typedef struct packed {
		logic [SEL_W-1:0]  index;
		logic              in_range;
		logic [FREQ_W-1:0] freq;
		logic              last;
	} res_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	function automatic count_t bump(input count_t c);
		return (c == '1) ? c : c + count_t'(1);
	endfunction

	function automatic logic [FREQ_W-1:0] report(input count_t c);
		logic [63:0] wide;
		wide = 64'(c);
		return (wide > 64'hFFFF_FFFF) ? '1 : FREQ_W'(wide);
	endfunction

endpackage

[rtl/ihist_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ihist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/ihist_front.sv]
// Front end: accepts commands, bins samples with a bit-serial divider, classifies
// reads and clears, and hands one operation at a time to the operation queue.
// Depends on ihist_pkg.
module ihist_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    command,
	input  logic signed [31:0]            sample_value,
	input  logic [9:0]                    bin_select,
	input  ihist_pkg::cfg_t               cfg,
	input  ihist_pkg::back_status_t       status,
	input  logic                          opq_full,
	output logic                          op_push,
	output ihist_pkg::op_t                op
);
	import ihist_pkg::*;

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MUL  = 3'd1;
	localparam logic [2:0] F_CHK  = 3'd2;
	localparam logic [2:0] F_DIV  = 3'd3;
	localparam logic [2:0] F_PUSH = 3'd4;

	logic [2:0]        state_q;
	logic [1:0]        cmd_q;
	logic [VAL_W:0]    diff_q;
	logic [SEL_W-1:0]  sel_q;
	logic [WID_W-1:0]  wid_q;
	logic [USED_W-1:0] used_q;
	logic [PROD_W-1:0] prod_q;
	logic [DIV_W-1:0]  rem_q;
	idx_t              quo_q;
	logic [STEP_W-1:0] step_q;
	op_t               op_q;

	logic              accept;
	logic [DIV_W-1:0]  divisor;
	logic              fits;
	idx_t              quo_n;
	logic              sel_ok;
	op_t               op_sel;
	op_t               op_div;

	assign full    = (state_q != F_IDLE) || status.clearing;
	assign accept  = push && !full;
	assign op_push = (state_q == F_PUSH) && !opq_full;
	assign op      = op_q;

	assign divisor = DIV_W'(wid_q) << step_q;
	assign fits    = rem_q >= divisor;
	assign quo_n   = (quo_q << 1) | idx_t'(fits);

	assign sel_ok  = CMP_W'(sel_q) < CMP_W'(used_q);

	always_comb begin
		op_sel          = '0;
		op_sel.index    = sel_q;
		op_sel.ram      = sel_ok;
		op_sel.clr      = sel_ok && (cmd_q == CMD_CLEAR);
		op_sel.addr     = idx_t'(sel_q);
		op_sel.in_range = sel_ok;
		op_sel.last     = sel_ok && (CMP_W'(sel_q) == CMP_W'(used_q) - CMP_W'(1));
	end

	always_comb begin
		op_div          = '0;
		op_div.ram      = 1'b1;
		op_div.inc      = 1'b1;
		op_div.addr     = quo_n;
		op_div.index    = SEL_W'(quo_n);
		op_div.in_range = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (accept) state_q <= F_MUL;
				F_MUL:  state_q <= F_CHK;
				F_CHK: begin
					if (cmd_q == CMD_SAMPLE && !diff_q[VAL_W]
					    && DIV_W'(diff_q[VAL_W-1:0]) < DIV_W'(prod_q)) begin
						state_q <= F_DIV;
					end else begin
						state_q <= F_PUSH;
					end
				end
				F_DIV:  if (step_q == '0) state_q <= F_PUSH;
				F_PUSH: if (!opq_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					cmd_q  <= command;
					sel_q  <= bin_select;
					diff_q <= {sample_value[VAL_W-1], sample_value}
					          - {cfg.start[VAL_W-1], cfg.start};
					wid_q  <= (cfg.width == '0) ? WID_W'(1) : cfg.width;
					used_q <= (CMP_W'(cfg.count) > CMP_W'(MAX_BINS))
					          ? USED_W'(MAX_BINS) : USED_W'(cfg.count);
				end
			end
			F_MUL: begin
				prod_q <= PROD_W'(used_q) * PROD_W'(wid_q);
			end
			F_CHK: begin
				rem_q  <= DIV_W'(diff_q[VAL_W-1:0]);
				quo_q  <= '0;
				step_q <= STEP_W'(IDX_W - 1);
				if (cmd_q == CMD_READ || cmd_q == CMD_CLEAR) begin
					op_q <= op_sel;
				end else begin
					op_q <= '0;
				end
			end
			F_DIV: begin
				if (fits) begin
					rem_q <= rem_q - divisor;
				end
				quo_q  <= quo_n;
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					op_q <= op_div;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

[rtl/ihist_opq.sv]
// Two-entry operation queue between the front end and the counter back end.
// Depends on ihist_pkg.
module ihist_opq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  ihist_pkg::op_t wdata,
	output logic           q_full,
	input  logic           rd,
	output ihist_pkg::op_t rdata,
	output logic           q_empty
);
	import ihist_pkg::*;

	op_t                mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wp_q;
	logic [Q_PTR_W-1:0] rp_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign q_full  = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign q_empty = cnt_q == '0;
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + Q_PTR_W'(1);
			if (do_rd) rp_q <= rp_q + Q_PTR_W'(1);
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end
endmodule

[rtl/ihist_back.sv]
// Back end: clears the bin store after reset, runs read-modify-write on bins and
// holds results in a two-entry output queue. Depends on ihist_pkg, ihist_ram.
module ihist_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ihist_pkg::op_t          op,
	input  logic                    op_empty,
	output logic                    op_pop,
	output ihist_pkg::back_status_t status,
	output ihist_pkg::res_t         res,
	output logic                    empty,
	input  logic                    pop
);
	import ihist_pkg::*;

	localparam logic [1:0] B_CLR  = 2'd0;
	localparam logic [1:0] B_IDLE = 2'd1;
	localparam logic [1:0] B_WB   = 2'd2;

	logic [1:0]         state_q;
	idx_t               clr_q;
	op_t                cur_q;
	res_t               out_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] owp_q;
	logic [Q_PTR_W-1:0] orp_q;
	logic [Q_CNT_W-1:0] ocnt_q;

	logic   we;
	idx_t   waddr;
	count_t wdata;
	count_t rdata;
	count_t next_cnt;
	logic   res_push;
	logic   res_pop;
	res_t   res_n;

	ihist_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(MAX_BINS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (op_pop),
		.raddr(op.addr),
		.rdata(rdata)
	);

	assign status.clearing = state_q == B_CLR;
	assign op_pop   = (state_q == B_IDLE) && !op_empty && (ocnt_q != Q_CNT_W'(Q_DEPTH));
	assign res_push = state_q == B_WB;
	assign empty    = ocnt_q == '0;
	assign res_pop  = pop && !empty;
	assign res      = out_q[orp_q];

	always_comb begin
		if (cur_q.clr) begin
			next_cnt = '0;
		end else if (cur_q.inc) begin
			next_cnt = bump(rdata);
		end else begin
			next_cnt = rdata;
		end
		res_n          = '0;
		res_n.index    = cur_q.index;
		res_n.in_range = cur_q.in_range;
		res_n.last     = cur_q.last;
		res_n.freq     = cur_q.ram ? report(next_cnt) : '0;
		if (state_q == B_CLR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else begin
			we    = (state_q == B_WB) && cur_q.ram && (cur_q.inc || cur_q.clr);
			waddr = cur_q.addr;
			wdata = next_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLR;
			clr_q   <= '0;
			owp_q   <= '0;
			orp_q   <= '0;
			ocnt_q  <= '0;
		end else begin
			case (state_q)
				B_CLR: begin
					clr_q <= clr_q + idx_t'(1);
					if (clr_q == idx_t'(MAX_BINS - 1)) state_q <= B_IDLE;
				end
				B_IDLE: if (op_pop) state_q <= B_WB;
				B_WB:   state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
			if (res_push) owp_q <= owp_q + Q_PTR_W'(1);
			if (res_pop)  orp_q <= orp_q + Q_PTR_W'(1);
			if (res_push && !res_pop) begin
				ocnt_q <= ocnt_q + Q_CNT_W'(1);
			end else if (res_pop && !res_push) begin
				ocnt_q <= ocnt_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			cur_q <= op;
		end
		if (res_push) begin
			out_q[owp_q] <= res_n;
		end
	end
endmodule

[rtl/interval_histogram.sv]
// Top level of the interval histogram: configuration registers and the
// front end, operation queue and back end. Depends on ihist_pkg and all ihist_* modules.
//
// channel   direction  handshake                 payload
// command   in         push / full               command, sample_value, bin_select
// result    out        pop / empty               bin_index, in_range, frequency, last_bin
// config    in         psel, penable, pwrite     paddr, pwdata -> prdata, pready
//
// A sample passes through the front end as accept, one multiply for the range limit,
// one check, then, if in range, one quotient bit per cycle of the serial divider.
// Reads and clears skip the divider; the back end reads the bin, then handles it in its write-back state.
// After reset the bin store is cleared one bin a cycle; full stays high.
// A stalled result side fills the output queue, then the operation queue, then raises full.
module interval_histogram (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [1:0]                       command,
	input  logic signed [31:0]               sample_value,
	input  logic [9:0]                       bin_select,
	output logic                             empty,
	input  logic                             pop,
	output logic [9:0]                       bin_index,
	output logic                             in_range,
	output logic [31:0]                      frequency,
	output logic                             last_bin,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ihist_pkg::ADDR_W-1:0]     paddr,
	input  logic [ihist_pkg::DATA_W-1:0]     pwdata,
	output logic [ihist_pkg::DATA_W-1:0]     prdata,
	output logic                             pready
);
	import ihist_pkg::*;

	cfg_t         cfg_q;
	back_status_t status;
	op_t          op_in;
	op_t          op_out;
	logic         op_push;
	logic         op_pop;
	logic         opq_full;
	logic         opq_empty;
	res_t         res;
	logic         cfg_wr;
	logic [1:0]   reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start <= START_RST;
			cfg_q.width <= WIDTH_RST;
			cfg_q.count <= COUNT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_START: cfg_q.start <= pwdata[VAL_W-1:0];
				REG_WIDTH: cfg_q.width <= pwdata[WID_W-1:0];
				REG_COUNT: cfg_q.count <= pwdata[CNTR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START: prdata = DATA_W'(cfg_q.start);
			REG_WIDTH: prdata = DATA_W'(cfg_q.width);
			REG_COUNT: prdata = DATA_W'(cfg_q.count);
			default:   prdata = '0;
		endcase
	end

	ihist_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.sample_value(sample_value),
		.bin_select  (bin_select),
		.cfg         (cfg_q),
		.status      (status),
		.opq_full    (opq_full),
		.op_push     (op_push),
		.op          (op_in)
	);

	ihist_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (op_push),
		.wdata  (op_in),
		.q_full (opq_full),
		.rd     (op_pop),
		.rdata  (op_out),
		.q_empty(opq_empty)
	);

	ihist_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op_out),
		.op_empty(opq_empty),
		.op_pop  (op_pop),
		.status  (status),
		.res     (res),
		.empty   (empty),
		.pop     (pop)
	);

	assign bin_index = res.index;
	assign in_range  = res.in_range;
	assign frequency = res.freq;
	assign last_bin  = res.last;
endmodule

[bench/histogram_checker.sv]
// Checker for the interval histogram: watches the command, result and register channels.
// Keeps its own bin tallies and register copy, and compares every result in order.
// Depends on ihist_pkg only.
module histogram_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            full,
	input  logic [1:0]                      command,
	input  logic signed [31:0]              sample_value,
	input  logic [9:0]                      bin_select,
	input  logic                            empty,
	input  logic                            pop,
	input  logic [9:0]                      bin_index,
	input  logic                            in_range,
	input  logic [31:0]                     frequency,
	input  logic                            last_bin,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ihist_pkg::ADDR_W-1:0]    paddr,
	input  logic [ihist_pkg::DATA_W-1:0]    pwdata,
	input  logic [ihist_pkg::DATA_W-1:0]    prdata,
	input  logic                            pready,
	output int                              mismatches,
	output int                              awaited,
	output int                              checked,
	output int                              binned
);
	import ihist_pkg::*;

	cfg_t   shadow;
	count_t bin_tally [MAX_BINS];
	res_t   due_q [$];

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40)
			$display("%0t mismatch in %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic tally_command(input logic [1:0] cmd, input logic signed [31:0] value,
			input logic [9:0] sel, output res_t r);
		longint          span;
		longint unsigned step;
		longint unsigned slot;
		longint unsigned used;
		r    = '0;
		used = (shadow.count > MAX_BINS) ? MAX_BINS : shadow.count;
		case (cmd)
			CMD_SAMPLE: begin
				span = longint'(value) - longint'($signed(shadow.start));
				step = (shadow.width == '0) ? 1 : shadow.width;
				if (span >= 0) begin
					slot = longint'(span) / step;
					if (slot < used) begin
						if (bin_tally[slot] != '1)
							bin_tally[slot] = bin_tally[slot] + count_t'(1);
						r.index    = slot[SEL_W-1:0];
						r.in_range = 1'b1;
						r.freq     = bin_tally[slot];
					end
				end
			end
			CMD_READ, CMD_CLEAR: begin
				r.index = sel;
				if (longint'(sel) < used) begin
					if (cmd == CMD_CLEAR)
						bin_tally[sel] = '0;
					r.in_range = 1'b1;
					r.freq     = bin_tally[sel];
					r.last     = (longint'(sel) == used - 1);
				end
			end
			default: ;
		endcase
	endtask

	task automatic compare_result(input res_t got, input res_t want);
		if (got.index !== want.index)
			note_mismatch("bin_index", 32'(got.index), 32'(want.index));
		if (got.in_range !== want.in_range)
			note_mismatch("in_range", 32'(got.in_range), 32'(want.in_range));
		if (got.freq !== want.freq)
			note_mismatch("frequency", got.freq, want.freq);
		if (got.last !== want.last)
			note_mismatch("last_bin", 32'(got.last), 32'(want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t seen;
		res_t want;
		if (!arst_n) begin
			shadow = '{start: START_RST, width: WIDTH_RST, count: COUNT_RST};
			foreach (bin_tally[i])
				bin_tally[i] = '0;
			due_q.delete();
			mismatches = 0;
			checked    = 0;
			binned     = 0;
			awaited   <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[ADDR_W-1:2])
						REG_START: shadow.start = pwdata[VAL_W-1:0];
						REG_WIDTH: shadow.width = pwdata[WID_W-1:0];
						REG_COUNT: shadow.count = pwdata[CNTR_W-1:0];
						default: ;
					endcase
				end else begin
					case (paddr[ADDR_W-1:2])
						REG_START: if (prdata[VAL_W-1:0] !== shadow.start)
							note_mismatch("bin_start readback", prdata, 32'(shadow.start));
						REG_WIDTH: if (prdata[WID_W-1:0] !== shadow.width)
							note_mismatch("bin_width readback", prdata, 32'(shadow.width));
						REG_COUNT: if (prdata[CNTR_W-1:0] !== shadow.count)
							note_mismatch("bin_count readback", prdata, 32'(shadow.count));
						default: ;
					endcase
				end
			end
			if (push && !full) begin
				tally_command(command, sample_value, bin_select, want);
				if (command == CMD_SAMPLE && want.in_range)
					binned++;
				due_q.push_back(want);
			end
			if (pop && !empty) begin
				seen = '{index: bin_index, in_range: in_range, freq: frequency,
					last: last_bin};
				if (due_q.size() == 0)
					note_mismatch("result with nothing pending", 32'(bin_index), 32'(0));
				else
					compare_result(seen, due_q.pop_front());
				checked++;
			end
			awaited <= due_q.size();
		end
	end

endmodule

[bench/testbench.sv]
// Top of the interval histogram bench: clock, reset, command and register stimulus.
// Instantiates interval_histogram and histogram_checker; depends on ihist_pkg.
module testbench;
	import ihist_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam longint     VAL_MIN   = -longint'(32'h8000_0000);
	localparam longint     VAL_MAX   = longint'(32'h7FFF_FFFF);

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 push         = 1'b0;
	logic                 full;
	logic [1:0]           command      = CMD_SAMPLE;
	logic signed [31:0]   sample_value = '0;
	logic [9:0]           bin_select   = '0;
	logic                 empty;
	logic                 pop          = 1'b0;
	logic [9:0]           bin_index;
	logic                 in_range;
	logic [31:0]          frequency;
	logic                 last_bin;
	logic                 psel         = 1'b0;
	logic                 penable      = 1'b0;
	logic                 pwrite       = 1'b0;
	logic [ADDR_W-1:0]    paddr        = '0;
	logic [DATA_W-1:0]    pwdata       = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	int mismatches;
	int awaited;
	int checked;
	int binned;

	logic [VAL_W-1:0]  cur_start = START_RST;
	logic [WID_W-1:0]  cur_width = WIDTH_RST;
	logic [CNTR_W-1:0] cur_count = COUNT_RST;

	bit calm      = 1'b0;
	bit hold_off  = 1'b0;
	bit hold_done = 1'b0;
	int n_sample  = 0;
	int n_read    = 0;
	int n_clear   = 0;
	int n_spare   = 0;
	int settings  = 1;

	interval_histogram u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.sample_value (sample_value),
		.bin_select   (bin_select),
		.empty        (empty),
		.pop          (pop),
		.bin_index    (bin_index),
		.in_range     (in_range),
		.frequency    (frequency),
		.last_bin     (last_bin),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	histogram_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.sample_value (sample_value),
		.bin_select   (bin_select),
		.empty        (empty),
		.pop          (pop),
		.bin_index    (bin_index),
		.in_range     (in_range),
		.frequency    (frequency),
		.last_bin     (last_bin),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.awaited      (awaited),
		.checked      (checked),
		.binned       (binned)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#(400_000 * 20);
		$display("timeout: results still outstanding or input never accepted");
		$display("FAILURE");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off && !hold_done) begin
				pop <= 1'b0;
				repeat (299) @(negedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(0, 16)) @(negedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic offer(input logic [1:0] cmd, input logic [31:0] value,
			input logic [9:0] sel);
		@(negedge clk);
		push         <= 1'b1;
		command      <= cmd;
		sample_value <= value;
		bin_select   <= sel;
		do @(posedge clk); while (full);
		case (cmd)
			CMD_SAMPLE: n_sample++;
			CMD_READ:   n_read++;
			CMD_CLEAR:  n_clear++;
			default:    n_spare++;
		endcase
	endtask

	task automatic idle_for(input int cycles);
		@(negedge clk);
		push <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] which,
			input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_W'({which, 2'b00});
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_bins(input logic [31:0] start, input logic [19:0] width,
			input logic [10:0] count);
		apb_access(1'b1, REG_START, start);
		apb_access(1'b1, REG_WIDTH, 32'(width));
		apb_access(1'b1, REG_COUNT, 32'(count));
		apb_access(1'b0, REG_START, '0);
		apb_access(1'b0, REG_WIDTH, '0);
		apb_access(1'b0, REG_COUNT, '0);
		cur_start = start;
		cur_width = width;
		cur_count = count;
		settings++;
	endtask

	function automatic longint unsigned bins_used();
		return (cur_count > MAX_BINS) ? MAX_BINS : cur_count;
	endfunction

	// sample aimed at a live bin or just outside the binned span
	function automatic logic [31:0] aimed_value();
		longint          lo;
		longint          v;
		longint unsigned w;
		longint unsigned used;
		w    = (cur_width == '0) ? 1 : cur_width;
		used = bins_used();
		lo   = longint'($signed(cur_start));
		case ($urandom_range(0, 9))
			0:       v = lo - 1;
			1:       v = lo;
			2:       v = lo + longint'(used * w) - 1;
			3:       v = lo + longint'(used * w);
			default: begin
				if (used == 0)
					v = lo + longint'($urandom_range(0, 99));
				else
					v = lo + longint'($urandom_range(0, 32'(used - 1))) * longint'(w)
						+ longint'($urandom_range(0, 32'(w - 1)));
			end
		endcase
		if (v < VAL_MIN || v > VAL_MAX)
			v = longint'($signed($urandom()));
		return v[31:0];
	endfunction

	function automatic logic [9:0] pick_bin();
		longint unsigned used;
		used = bins_used();
		if (used == 0 || $urandom_range(0, 3) == 0)
			return 10'($urandom());
		return 10'($urandom_range(0, 32'(used - 1)));
	endfunction

	task automatic random_command();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			offer(CMD_SAMPLE, aimed_value(), 10'($urandom()));
		else if (roll < 75)
			offer(CMD_SAMPLE, $urandom(), 10'($urandom()));
		else if (roll < 88)
			offer(CMD_READ, $urandom(), pick_bin());
		else if (roll < 96)
			offer(CMD_CLEAR, $urandom(), pick_bin());
		else
			offer(CMD_SPARE, $urandom(), 10'($urandom()));
	endtask

	task automatic run_phase(input int items);
		for (int i = 0; i < items; i++) begin
			if (!calm && $urandom_range(0, 7) == 0)
				idle_for($urandom_range(1, 17));
			random_command();
		end
		idle_for(1);
		wait (awaited == 0);
	endtask

	task automatic random_settings();
		logic [31:0] start;
		logic [19:0] width;
		logic [10:0] count;
		start = ($urandom_range(0, 1) == 0) ? $urandom() : 32'($urandom_range(0, 4000)) - 2000;
		width = ($urandom_range(0, 2) == 0) ? 20'($urandom()) : 20'($urandom_range(1, 64));
		count = ($urandom_range(0, 1) == 0) ? 11'($urandom_range(1, 1024)) : 11'($urandom());
		program_bins(start, width, count);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// hold until the store clearing pass has finished
		do @(posedge clk); while (full);

		offer(CMD_SAMPLE, 32'd0, 10'd0);
		offer(CMD_SAMPLE, 32'd9, 10'd0);
		offer(CMD_SAMPLE, 32'd10, 10'd0);
		offer(CMD_SAMPLE, 32'd99, 10'd0);
		offer(CMD_SAMPLE, 32'd100, 10'd0);
		offer(CMD_SAMPLE, 32'hFFFF_FFFF, 10'd0);
		offer(CMD_SAMPLE, 32'h8000_0000, 10'd0);
		offer(CMD_SAMPLE, 32'h7FFF_FFFF, 10'd0);
		offer(CMD_READ, '0, 10'd0);
		offer(CMD_READ, '0, 10'd9);
		offer(CMD_READ, '0, 10'd10);
		offer(CMD_READ, '0, 10'h3FF);
		offer(CMD_CLEAR, '0, 10'd0);
		offer(CMD_READ, '0, 10'd0);
		offer(CMD_CLEAR, '0, 10'h3FF);
		offer(CMD_SPARE, 32'hFFFF_FFFF, 10'h3FF);

		hold_off = 1'b1;
		run_phase(80);

		program_bins(32'h8000_0000, 20'd1, 11'd1024);
		offer(CMD_SAMPLE, 32'h8000_0000, 10'd0);
		offer(CMD_SAMPLE, 32'h8000_03FF, 10'd0);
		offer(CMD_SAMPLE, 32'h8000_0400, 10'd0);
		offer(CMD_READ, '0, 10'h3FF);
		offer(CMD_CLEAR, '0, 10'h3FF);
		run_phase(100);

		program_bins(32'h7FFF_FFFF, 20'hF_FFFF, 11'd1);
		run_phase(60);

		calm = 1'b1;
		program_bins($urandom(), 20'd0, 11'h7FF);
		run_phase(100);
		calm = 1'b0;

		program_bins($urandom(), 20'($urandom()), 11'd0);
		offer(CMD_READ, '0, 10'd0);
		offer(CMD_SAMPLE, cur_start, 10'd0);
		run_phase(40);

		repeat (3) begin
			random_settings();
			run_phase(80);
		end

		calm = 1'b1;
		random_settings();
		run_phase(120);

		repeat (40) @(posedge clk);
		$display("ran %0d commands: %0d samples, %0d in a bin, %0d reads, %0d clears, %0d spare",
			n_sample + n_read + n_clear + n_spare, n_sample, binned, n_read, n_clear, n_spare);
		$display("%0d results compared across %0d register settings", checked, settings);
		if (mismatches == 0 && awaited == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
